/* sv/plid_pkg.sv */
package plid_pkg;

    typedef logic signed [31:0] t_word;

    // command codes
    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_POS   = 3'd1;
    localparam logic [2:0] CMD_INS_END   = 3'd2;
    localparam logic [2:0] CMD_REM_FRONT = 3'd3;
    localparam logic [2:0] CMD_REM_POS   = 3'd4;
    localparam logic [2:0] CMD_REM_END   = 3'd5;

    // status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [2:0] command;
        t_word      value;
        logic [6:0] position;
    } t_in;

    typedef struct packed {
        t_word      removed_value;
        logic [1:0] status;
        logic [6:0] length;
    } t_out;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic  ins;
        logic  rem;
        t_word value;
    } t_cell_ctrl;

endpackage

/* sv/plid_cell.sv */
module plid_cell
    import plid_pkg::*;
#(
    parameter int AW  = 6,
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  t_cell_ctrl    i_ctrl,
    input  logic [AW-1:0] i_at,
    input  t_word         i_left,
    input  t_word         i_right,
    output t_word         o_data,
    output t_word         o_pick
);

    localparam logic [AW-1:0] MY_IDX = AW'(IDX);

    t_word r_data;
    t_word n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins) begin
            // cells behind the insert point move one place back
            if (MY_IDX > i_at) begin
                n_data = i_left;
            end else if (MY_IDX == i_at) begin
                n_data = i_ctrl.value;
            end
        end else if (i_ctrl.rem) begin
            // the removed cell and all behind it pull from the next one
            if (MY_IDX >= i_at) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_pick = (i_ctrl.rem && (MY_IDX == i_at)) ? r_data : '0;

endmodule

/* sv/positional_list_insert_delete.sv */
// Ordered list of signed 32-bit entries held in a row of shifting cells,
// index 0 at the front.
// Input channel i_in_valid / o_in_ready carries one command transaction
// (command, value, position); output channel o_out_valid / i_out_ready
// returns one result transaction per command (removed value, status, length).
// An accepted command changes the cells at its acceptance edge: every entry
// behind the point of change moves one cell in the same cycle, whatever the
// position. The removed value is picked out through a two-level OR tree:
// the group registers of the first level load at acceptance, and the
// second level feeds the output register, which loads once it is free.
// o_in_ready is high again in the cycle after the result is loaded, so no
// new command is taken before the last result reaches the output register.
// When the receiver stalls, the finished result waits in the output
// register; one more command can still be accepted, and its result waits
// in the group registers, with o_in_ready low, until the output frees up.
// Reset (synchronous, active low) empties the list and drops any pending
// result; cell contents are not cleared and are never read before written.
// The length field is 7 bits wide; CAPACITY above 127 is not reported
// correctly on it.
module positional_list_insert_delete
    import plid_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    function automatic int f_root_ceil(input int n);
        int g;
        g = 1;
        while (g * g < n) g++;
        return g;
    endfunction

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 7) ? CW : 7;
    localparam int GS = f_root_ceil(CAPACITY);
    localparam int NG = (CAPACITY + GS - 1) / GS;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SUM  = 1'b1;

    logic          r_state;
    logic          n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_out          r_out;
    logic [1:0]    r_status;

    logic          w_accept;
    logic          w_empty;
    logic          w_full;
    logic [PW-1:0] w_pos_ext;
    logic [PW-1:0] w_cnt_ext;
    logic          w_pos_gt;
    logic          w_ins;
    logic          w_rem;
    logic [AW-1:0] w_at;
    logic [1:0]    w_status;
    logic          w_load;
    t_cell_ctrl    w_ctrl;

    t_word w_data [CAPACITY];
    t_word w_pick [CAPACITY];
    t_word r_grp  [NG];
    t_word n_grp  [NG];
    t_word w_removed;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count == CAP_CNT);
    assign w_pos_ext = PW'(i_in_data.position);
    assign w_cnt_ext = PW'(r_count);
    assign w_pos_gt  = (w_pos_ext > w_cnt_ext);

    // command decode
    always_comb begin
        w_ins    = 1'b0;
        w_rem    = 1'b0;
        w_at     = '0;
        w_status = ST_DONE;
        unique case (i_in_data.command)
            CMD_INS_FRONT: begin
                if (w_full) w_status = ST_FULL;
                else        w_ins    = 1'b1;
            end
            CMD_INS_POS: begin
                priority if (w_empty) begin
                    w_ins = 1'b1;
                end else if (w_pos_gt) begin
                    w_status = ST_BADPOS;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                    w_at  = AW'(i_in_data.position);
                end
            end
            CMD_INS_END: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                    w_at  = AW'(r_count);
                end
            end
            CMD_REM_FRONT: begin
                if (w_empty) w_status = ST_EMPTY;
                else         w_rem    = 1'b1;
            end
            CMD_REM_POS: begin
                priority if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_pos_gt) begin
                    w_status = ST_BADPOS;
                end else begin
                    w_rem = 1'b1;
                    // position equal to the length takes the last entry
                    if (w_pos_ext == w_cnt_ext) w_at = AW'(r_count - CW'(1));
                    else                        w_at = AW'(i_in_data.position);
                end
            end
            CMD_REM_END: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_rem = 1'b1;
                    w_at  = AW'(r_count - CW'(1));
                end
            end
            default: ;
        endcase
    end

    assign w_ctrl.ins   = w_accept && w_ins;
    assign w_ctrl.rem   = w_accept && w_rem;
    assign w_ctrl.value = i_in_data.value;

    // the cell row
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_word w_left;
        t_word w_right;
        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[i+1];
        end
        plid_cell #(
            .AW  (AW),
            .IDX (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_at    (w_at),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[i]),
            .o_pick  (w_pick[i])
        );
    end

    // first tree level: one group register per GS cells
    for (genvar g = 0; g < NG; g++) begin : g_grp
        localparam int LO = g * GS;
        localparam int HI = ((g + 1) * GS < CAPACITY) ? (g + 1) * GS : CAPACITY;
        always_comb begin
            n_grp[g] = '0;
            for (int k = LO; k < HI; k++) begin
                n_grp[g] = n_grp[g] | w_pick[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_accept) begin
                r_grp[g] <= n_grp[g];
            end
        end
    end

    // second tree level feeds the output register
    always_comb begin
        w_removed = '0;
        for (int g = 0; g < NG; g++) begin
            w_removed = w_removed | r_grp[g];
        end
    end

    assign w_load = (r_state == S_SUM) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SUM;
                    if (w_ins)      n_count = r_count + CW'(1);
                    else if (w_rem) n_count = r_count - CW'(1);
                end
            end
            S_SUM: begin
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load)           r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
        end
        if (w_load) begin
            r_out.removed_value <= w_removed;
            r_out.status        <= r_status;
            r_out.length        <= 7'(r_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("entry count above capacity");

    a_ins_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_ins) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list");

    a_rem_shrinks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_rem) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("remove did not shrink the list");

    a_len_matches : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_out_data.length == 7'(r_count)))
        else $error("reported length differs from entry count");

    a_fail_no_value : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_status != ST_DONE)) |=> (o_out_data.removed_value == '0))
        else $error("failed command returned a value");

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
    import plid_pkg::*;

    localparam int LIST_DEPTH  = 64;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 8;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    t_out out_data;

    // golden list contents, index 0 is the front
    t_word list_q[$];
    t_out  expected_q[$];

    int idle_pct   = 0;
    int stall_pct  = 0;
    int quiet_cnt  = 0;
    int mismatches = 0;
    int n_sent     = 0;
    int n_checked  = 0;
    int peak_len   = 0;
    int n_full     = 0;
    int n_badpos   = 0;
    int n_empty    = 0;

    positional_list_insert_delete #(
        .CAPACITY(LIST_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cnt <= 0;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    initial begin
        while (quiet_cnt < QUIET_LIMIT) @(posedge i_clk);
        $display("tb: errors");
        $finish;
    end

    // applies one command to the golden list and returns the result it must give
    function automatic t_out predict_list_op(input t_in c);
        t_out r;
        int   n;
        int   idx;
        n = list_q.size();
        r = '0;
        r.status = ST_DONE;
        case (c.command)
            CMD_INS_FRONT, CMD_INS_END: begin
                if (n >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else if (c.command == CMD_INS_FRONT) begin
                    list_q.push_front(c.value);
                end else begin
                    list_q.push_back(c.value);
                end
            end
            CMD_INS_POS: begin
                // empty list takes the value at the front whatever the position
                if (n == 0) begin
                    list_q.push_front(c.value);
                end else if (c.position > n) begin
                    r.status = ST_BADPOS;
                end else if (n >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else if (c.position == n) begin
                    list_q.push_back(c.value);
                end else begin
                    list_q.insert(c.position, c.value);
                end
            end
            CMD_REM_FRONT, CMD_REM_END: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else if (c.command == CMD_REM_FRONT) begin
                    r.removed_value = list_q.pop_front();
                end else begin
                    r.removed_value = list_q.pop_back();
                end
            end
            CMD_REM_POS: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else if (c.position > n) begin
                    r.status = ST_BADPOS;
                end else begin
                    // position equal to the length takes the last entry
                    idx = (c.position == n) ? n - 1 : int'(c.position);
                    r.removed_value = list_q[idx];
                    list_q.delete(idx);
                end
            end
            default: ;
        endcase
        r.length = 7'(list_q.size());
        if (list_q.size() > peak_len) peak_len = list_q.size();
        if (r.status == ST_FULL) n_full++;
        if (r.status == ST_BADPOS) n_badpos++;
        if (r.status == ST_EMPTY) n_empty++;
        return r;
    endfunction

    function automatic void check_result(input t_out got);
        t_out want;
        n_checked++;
        if (expected_q.size() == 0) begin
            $error("result transaction with nothing expected: %p", got);
            mismatches++;
        end else begin
            want = expected_q.pop_front();
            if (got.removed_value !== want.removed_value) begin
                $error("removed_value: expected %0d, got %0d",
                       want.removed_value, got.removed_value);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.length !== want.length) begin
                $error("length: expected %0d, got %0d", want.length, got.length);
                mismatches++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            check_result(out_data);
        end
    end

    task automatic send_cmd(input logic [2:0] cmd, input t_word val, input logic [6:0] pos);
        t_in c;
        c.command  = cmd;
        c.value    = val;
        c.position = pos;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        expected_q.push_back(predict_list_op(c));
        n_sent++;
    endtask

    function automatic t_word pick_value();
        case ($urandom_range(19))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [6:0] pick_position();
        int n;
        int r;
        n = list_q.size();
        r = $urandom_range(99);
        if (r < 75) return 7'($urandom_range(n));
        if (r < 90 && n < LIST_DEPTH) return 7'($urandom_range(LIST_DEPTH, n + 1));
        return 7'($urandom_range(LIST_DEPTH));
    endfunction

    function automatic logic [2:0] pick_command(input bit want_insert);
        case ($urandom_range(2))
            0:       return want_insert ? CMD_INS_FRONT : CMD_REM_FRONT;
            1:       return want_insert ? CMD_INS_POS : CMD_REM_POS;
            default: return want_insert ? CMD_INS_END : CMD_REM_END;
        endcase
    endfunction

    task automatic test_empty_list();
        send_cmd(CMD_REM_FRONT, 32'sd5, 7'd0);
        send_cmd(CMD_REM_POS, 32'sd5, 7'd0);
        send_cmd(CMD_REM_END, 32'sd5, 7'd0);
        send_cmd(CMD_REM_POS, 32'sd5, 7'd64);
        // insert at a far position on an empty list lands at the front
        send_cmd(CMD_INS_POS, 32'sh8000_0000, 7'd64);
        // removing the only entry through position equal to length
        send_cmd(CMD_REM_POS, '0, 7'd1);
    endtask

    task automatic test_edge_positions();
        send_cmd(CMD_INS_FRONT, 32'sh7fff_ffff, 7'd0);
        send_cmd(CMD_INS_END, -1, 7'd0);
        send_cmd(CMD_INS_POS, '0, 7'd2);
        send_cmd(CMD_INS_POS, 32'sh5555_5555, 7'd1);
        send_cmd(CMD_INS_POS, 32'shaaaa_aaaa, 7'd0);
        send_cmd(CMD_INS_POS, 32'sd1, 7'd6);
        send_cmd(CMD_REM_POS, '0, 7'd6);
        send_cmd(CMD_REM_POS, '0, 7'd5);
        send_cmd(CMD_REM_POS, '0, 7'd0);
        send_cmd(CMD_REM_POS, '0, 7'd1);
        send_cmd(CMD_REM_END, '0, 7'd0);
        send_cmd(CMD_REM_FRONT, '0, 7'd0);
    endtask

    task automatic test_fill_and_drain();
        while (list_q.size() < LIST_DEPTH) begin
            send_cmd(pick_command(1'b1), pick_value(), 7'($urandom_range(list_q.size())));
        end
        send_cmd(CMD_INS_FRONT, pick_value(), 7'd0);
        send_cmd(CMD_INS_END, pick_value(), 7'd0);
        send_cmd(CMD_INS_POS, pick_value(), 7'd64);
        // bad position wins over full
        send_cmd(CMD_INS_POS, pick_value(), 7'd127);
        send_cmd(CMD_REM_POS, '0, 7'd65);
        send_cmd(CMD_REM_POS, '0, 7'd64);
        while (list_q.size() > 0) begin
            send_cmd(pick_command(1'b0), pick_value(), pick_position());
        end
    endtask

    task automatic test_random_mix(input int count);
        int n;
        int ins_pct;
        repeat (count) begin
            n = list_q.size();
            ins_pct = (n < 8) ? 75 : (n > 56) ? 25 : 50;
            send_cmd(pick_command($urandom_range(99) < ins_pct), pick_value(), pick_position());
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_edge_positions();
        test_fill_and_drain();
        test_random_mix(90);

        idle_pct  = 62;
        stall_pct = 0;
        test_random_mix(90);

        idle_pct  = 0;
        stall_pct = 62;
        test_random_mix(90);

        idle_pct  = 26;
        stall_pct = 26;
        test_random_mix(90);
        test_fill_and_drain();

        @(negedge i_clk);
        in_valid  <= 1'b0;
        stall_pct = 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("tb: %0d commands, %0d results compared, peak length %0d",
                 n_sent, n_checked, peak_len);
        $display("tb: refusals seen - full %0d, bad position %0d, empty %0d",
                 n_full, n_badpos, n_empty);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

/* positional_list_insert_delete.f */
sv/plid_pkg.sv
sv/plid_cell.sv
sv/positional_list_insert_delete.sv
bench/tb.sv
